// ----- sv/gia_pkg.sv -----
package gia_pkg;

  localparam int MAX_ENTITIES_DEFAULT = 1024;
  localparam int GEN_W = 8;
  localparam int STATUS_W = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SLOT  = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIST,
    ST_GEN,
    ST_FINISH
  } state_t;

endpackage

// ----- sv/gia_ram.sv -----
module gia_ram #(
  parameter int DEPTH = gia_pkg::MAX_ENTITIES_DEFAULT,
  parameter int WIDTH = gia_pkg::GEN_W,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // rdata holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/gia_seq.sv -----
module gia_seq #(
  parameter int MAX_ENTITIES = gia_pkg::MAX_ENTITIES_DEFAULT,
  localparam int INDEX_W = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1,
  localparam int COUNT_W = $clog2(MAX_ENTITIES + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  // request side
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      command,
  input  logic [INDEX_W-1:0]        free_index,
  // result side
  output logic                      out_valid,
  input  logic                      out_stall,
  output gia_pkg::status_t          status,
  output logic [INDEX_W-1:0]        id_index,
  output logic [gia_pkg::GEN_W-1:0] id_generation,
  // free list memory
  output logic                      list_re,
  output logic [INDEX_W-1:0]        list_raddr,
  input  logic [INDEX_W-1:0]        list_rdata,
  output logic                      list_we,
  output logic [INDEX_W-1:0]        list_waddr,
  output logic [INDEX_W-1:0]        list_wdata,
  // generation memory
  output logic                      gen_re,
  output logic [INDEX_W-1:0]        gen_raddr,
  input  logic [gia_pkg::GEN_W-1:0] gen_rdata,
  output logic                      gen_we,
  output logic [INDEX_W-1:0]        gen_waddr,
  output logic [gia_pkg::GEN_W-1:0] gen_wdata
);

  import gia_pkg::*;

  typedef enum logic [2:0] {
    OP_POP,
    OP_FRESH,
    OP_FULL,
    OP_FREE,
    OP_BAD
  } op_t;

  localparam logic [COUNT_W-1:0] CAPACITY = COUNT_W'(MAX_ENTITIES);
  localparam logic [INDEX_W-1:0] LAST_POS = INDEX_W'(MAX_ENTITIES - 1);

  state_t              state, state_next;
  op_t                 op, op_sel;
  logic [INDEX_W-1:0]  idx;
  logic [COUNT_W-1:0]  high_water;
  logic [INDEX_W-1:0]  head;
  logic [INDEX_W-1:0]  tail;
  logic [COUNT_W-1:0]  count;

  logic                accept;
  logic                out_open;
  logic                done;
  status_t             res_status;
  logic [INDEX_W-1:0]  res_index;
  logic [GEN_W-1:0]    res_gen;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_open = !out_valid || !out_stall;
  assign done     = ((state == ST_GEN) || (state == ST_FINISH)) && out_open;

  // decision made from the counters at accept time
  always_comb begin
    if (command == CMD_ALLOC) begin
      if (count != '0) begin
        op_sel = OP_POP;
      end else if (high_water != CAPACITY) begin
        op_sel = OP_FRESH;
      end else begin
        op_sel = OP_FULL;
      end
    end else begin
      if ((COUNT_W'(free_index) >= high_water) || (count == CAPACITY)) begin
        op_sel = OP_BAD;
      end else begin
        op_sel = OP_FREE;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority case (op_sel)
            OP_POP:  state_next = ST_LIST;
            OP_FREE: state_next = ST_GEN;
            default: state_next = ST_FINISH;
          endcase
        end
      end
      ST_LIST: state_next = ST_GEN;
      ST_GEN, ST_FINISH: begin
        if (out_open) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    res_status = STATUS_OK;
    res_index  = '0;
    res_gen    = '0;
    unique case (op)
      OP_POP: begin
        res_index = idx;
        res_gen   = gen_rdata;
      end
      OP_FRESH: res_index = high_water[INDEX_W-1:0];
      OP_FULL:  res_status = STATUS_NO_SLOT;
      OP_BAD:   res_status = STATUS_BAD_FREE;
      OP_FREE:  res_status = STATUS_OK;
      default:  res_status = STATUS_OK;
    endcase
  end

  // memory ports
  assign list_re    = accept;
  assign list_raddr = head;
  assign list_we    = done && (op == OP_FREE);
  assign list_waddr = tail;
  assign list_wdata = idx;

  assign gen_re    = accept || (state == ST_LIST);
  assign gen_raddr = (state == ST_LIST) ? list_rdata : free_index;
  assign gen_we    = done && ((op == OP_FREE) || (op == OP_FRESH));
  assign gen_waddr = (op == OP_FRESH) ? high_water[INDEX_W-1:0] : idx;
  assign gen_wdata = (op == OP_FREE) ? gen_rdata + GEN_W'(1) : '0;

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= op_sel;
      idx <= free_index;
    end else if (state == ST_LIST) begin
      idx <= list_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_water <= '0;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
    end else if (done) begin
      priority case (op)
        OP_POP: begin
          head  <= (head == LAST_POS) ? '0 : head + INDEX_W'(1);
          count <= count - COUNT_W'(1);
        end
        OP_FRESH: high_water <= high_water + COUNT_W'(1);
        OP_FREE: begin
          tail  <= (tail == LAST_POS) ? '0 : tail + INDEX_W'(1);
          count <= count + COUNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status        <= res_status;
      id_index      <= res_index;
      id_generation <= res_gen;
    end
  end

endmodule

// ----- sv/generational_id_allocator_top.sv -----
// channel  | valid     | stall     | word
// ---------+-----------+-----------+-------------------------------------
// request  | in_valid  | in_stall  | command, free_index
// result   | out_valid | out_stall | status, id_index, id_generation
//
// One request at a time; every request gives one result word.
// Allocate from the free list: free list read, then generation read.
// Free: generation read-modify-write. Fresh slot or error: straight to the final step.
// Results sit in an output register; the next request is taken while it waits.
// A stalled result holds the sequencer in its final step until the word leaves.
// Synchronous reset clears counters and control; both memories need no clearing.
module generational_id_allocator_top #(
  parameter int MAX_ENTITIES = gia_pkg::MAX_ENTITIES_DEFAULT,
  localparam int INDEX_W = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command,
  input  logic [INDEX_W-1:0]           free_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gia_pkg::STATUS_W-1:0] status,
  output logic [INDEX_W-1:0]           id_index,
  output logic [gia_pkg::GEN_W-1:0]    id_generation
);

  import gia_pkg::*;

  status_t             status_enum;
  logic                list_re, list_we;
  logic [INDEX_W-1:0]  list_raddr, list_rdata, list_waddr, list_wdata;
  logic                gen_re, gen_we;
  logic [INDEX_W-1:0]  gen_raddr, gen_waddr;
  logic [GEN_W-1:0]    gen_rdata, gen_wdata;

  assign status = status_enum;

  gia_seq #(
    .MAX_ENTITIES(MAX_ENTITIES)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .free_index   (free_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status_enum),
    .id_index     (id_index),
    .id_generation(id_generation),
    .list_re      (list_re),
    .list_raddr   (list_raddr),
    .list_rdata   (list_rdata),
    .list_we      (list_we),
    .list_waddr   (list_waddr),
    .list_wdata   (list_wdata),
    .gen_re       (gen_re),
    .gen_raddr    (gen_raddr),
    .gen_rdata    (gen_rdata),
    .gen_we       (gen_we),
    .gen_waddr    (gen_waddr),
    .gen_wdata    (gen_wdata)
  );

  gia_ram #(
    .DEPTH(MAX_ENTITIES),
    .WIDTH(INDEX_W)
  ) u_free_list (
    .clk  (clk),
    .re   (list_re),
    .raddr(list_raddr),
    .rdata(list_rdata),
    .we   (list_we),
    .waddr(list_waddr),
    .wdata(list_wdata)
  );

  gia_ram #(
    .DEPTH(MAX_ENTITIES),
    .WIDTH(GEN_W)
  ) u_gen_store (
    .clk  (clk),
    .re   (gen_re),
    .raddr(gen_raddr),
    .rdata(gen_rdata),
    .we   (gen_we),
    .waddr(gen_waddr),
    .wdata(gen_wdata)
  );

  // an accepted request blocks the request after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted back to back");

  // error words carry zero identifier fields
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status_enum != STATUS_OK) |-> (id_index == '0) && (id_generation == '0))
    else $error("error word with nonzero identifier");

  // a new result word only ends a request in flight
  a_result_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without request");

  // no write to either store while idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !list_we && !gen_we)
    else $error("memory write while idle");

endmodule
